FILE: rtl/simplified_aes_cipher_defines.svh
// Assertion macros shared by the simplified AES checker.
`ifndef SIMPLIFIED_AES_CIPHER_DEFINES_SVH
`define SIMPLIFIED_AES_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SAES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SAES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/saes_pkg.sv
// Package with the S-AES tables, constants and round functions.
`timescale 1ns / 1ps

package saes_pkg;

    // Operation codes carried in tuser.
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Key schedule round constants.
    localparam logic [7:0] RCON_1 = 8'h80;
    localparam logic [7:0] RCON_2 = 8'h30;

    // Field polynomial x^4 + x + 1.
    localparam logic [4:0] GF_POLY = 5'b10011;

    // Column mixing matrix entries: diagonal and off-diagonal.
    localparam logic [3:0] MIX_ENC_DIAG = 4'h1;
    localparam logic [3:0] MIX_ENC_OFF  = 4'h4;
    localparam logic [3:0] MIX_DEC_DIAG = 4'h9;
    localparam logic [3:0] MIX_DEC_OFF  = 4'h2;

    // Forward and inverse nibble substitution tables.
    localparam logic [3:0] SBOX [16] = '{
        4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
        4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
    };
    localparam logic [3:0] INV_SBOX [16] = '{
        4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
        4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
    };

    // The three round keys derived from the cipher key.
    typedef struct packed {
        logic [15:0] k1;
        logic [15:0] k2;
        logic [15:0] k3;
    } round_keys_t;

    // Multiplication in GF(2^4) modulo x^4 + x + 1.
    function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] acc_a;
        logic [3:0] prod;
        prod  = '0;
        acc_a = {1'b0, a};
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
            begin
                prod = prod ^ acc_a[3:0];
            end
            acc_a = {acc_a[3:0], 1'b0};
            if (acc_a[4])
            begin
                acc_a = acc_a ^ GF_POLY;
            end
        end
        return prod;
    endfunction

    // Forward substitution of all four nibbles.
    function automatic logic [15:0] sub16(input logic [15:0] v);
        return {SBOX[v[15:12]], SBOX[v[11:8]], SBOX[v[7:4]], SBOX[v[3:0]]};
    endfunction

    // Inverse substitution of all four nibbles.
    function automatic logic [15:0] inv_sub16(input logic [15:0] v);
        return {INV_SBOX[v[15:12]], INV_SBOX[v[11:8]], INV_SBOX[v[7:4]], INV_SBOX[v[3:0]]};
    endfunction

    // Substitution of one key byte.
    function automatic logic [7:0] sub8(input logic [7:0] v);
        return {SBOX[v[7:4]], SBOX[v[3:0]]};
    endfunction

    // Nibble rotation of one key byte.
    function automatic logic [7:0] rot8(input logic [7:0] v);
        return {v[3:0], v[7:4]};
    endfunction

    // Swap nibbles 1 and 3; the step is its own inverse.
    function automatic logic [15:0] shift_row(input logic [15:0] v);
        return {v[15:12], v[3:0], v[7:4], v[11:8]};
    endfunction

    // Multiply each column by the matrix {diag, off; off, diag}.
    function automatic logic [15:0] mix_cols(input logic [15:0] v,
                                             input logic [3:0] diag,
                                             input logic [3:0] off);
        logic [3:0] r0;
        logic [3:0] r1;
        logic [3:0] r2;
        logic [3:0] r3;
        r0 = gf_mul(diag, v[15:12]) ^ gf_mul(off, v[11:8]);
        r1 = gf_mul(off, v[15:12]) ^ gf_mul(diag, v[11:8]);
        r2 = gf_mul(diag, v[7:4]) ^ gf_mul(off, v[3:0]);
        r3 = gf_mul(off, v[7:4]) ^ gf_mul(diag, v[3:0]);
        return {r0, r1, r2, r3};
    endfunction

    // Key expansion into three round keys.
    function automatic round_keys_t key_expand(input logic [15:0] key);
        logic [7:0] w2;
        logic [7:0] w3;
        logic [7:0] w4;
        logic [7:0] w5;
        round_keys_t keys;
        w2 = key[15:8] ^ RCON_1 ^ sub8(rot8(key[7:0]));
        w3 = w2 ^ key[7:0];
        w4 = w2 ^ RCON_2 ^ sub8(rot8(w3));
        w5 = w4 ^ w3;
        keys.k1 = key;
        keys.k2 = {w2, w3};
        keys.k3 = {w4, w5};
        return keys;
    endfunction

endpackage

FILE: rtl/saes_key_exp.sv
// Key register that holds the expanded round keys of the cipher key.
`timescale 1ns / 1ps

module saes_key_exp
    import saes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output round_keys_t round_keys
);

    round_keys_t keys_reg;
    round_keys_t keys_next;

    // Expand the key as it is written, so the rounds see ready keys.
    always_comb
    begin
        keys_next = keys_reg;
        if (cfg_wr_en)
        begin
            keys_next = key_expand(cfg_wr_data);
        end
    end

    // After reset the cipher runs with the expansion of the zero key.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg <= key_expand(16'h0000);
        end
        else
        begin
            keys_reg <= keys_next;
        end
    end

    assign round_keys = keys_reg;

endmodule

FILE: rtl/saes_round_core.sv
// Single-pass S-AES datapath for both encryption and decryption.
`timescale 1ns / 1ps

module saes_round_core
    import saes_pkg::*;
(
    input  logic        operation,
    input  logic [15:0] block_in,
    input  round_keys_t round_keys,
    output logic [15:0] block_out
);

    logic [15:0] enc_a;
    logic [15:0] enc_b;
    logic [15:0] enc_res;
    logic [15:0] dec_a;
    logic [15:0] dec_b;
    logic [15:0] dec_res;

    // Encryption: key add, full round, key add, final round, key add.
    always_comb
    begin
        enc_a   = shift_row(sub16(block_in ^ round_keys.k1));
        enc_b   = mix_cols(enc_a, MIX_ENC_DIAG, MIX_ENC_OFF) ^ round_keys.k2;
        enc_res = shift_row(sub16(enc_b)) ^ round_keys.k3;
    end

    // Decryption: the inverse steps in reverse order.
    always_comb
    begin
        dec_a   = inv_sub16(shift_row(block_in ^ round_keys.k3)) ^ round_keys.k2;
        dec_b   = mix_cols(dec_a, MIX_DEC_DIAG, MIX_DEC_OFF);
        dec_res = inv_sub16(shift_row(dec_b)) ^ round_keys.k1;
    end

    // Select the direction asked for by the request.
    always_comb
    begin
        case (operation)
            OP_ENCRYPT: block_out = enc_res;
            OP_DECRYPT: block_out = dec_res;
            default:    block_out = enc_res;
        endcase
    end

endmodule

FILE: rtl/simplified_aes_cipher.sv
// Top level of the simplified AES cipher on 16-bit blocks.
//
// Input channel (s_*): each request carries one 16-bit block in s_tdata and
// the operation in s_tuser (0 encrypts, 1 decrypts). Output channel (m_*):
// one 16-bit result block in m_tdata per request, in request order. The key
// must be loaded through cfg_wr_en and cfg_wr_data only while no request is
// in flight, unchecked by the block; it is expanded to round keys on write.
//
// A request is captured in the input register, passes the round logic and
// lands in the result register, which drives m_tvalid and m_tdata. One
// request is taken every cycle while the receiver keeps m_tready high; the
// rate is set by the single pass of round logic between the input and
// result registers.
//
// Reset clears both stages and loads the round keys of the all-zero key.
// When the receiver holds m_tready low, the result stays on m_tdata and the
// input register still fills once; further requests then wait on s_tready.
`timescale 1ns / 1ps

module simplified_aes_cipher
    import saes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] block_in
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] block_out
);

    round_keys_t round_keys;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        in_op_reg;
    logic [15:0] in_block_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_block_reg;
    logic [15:0] core_block;
    logic        in_accept;
    logic        stage_move;
    logic        out_free;

    saes_key_exp u_key_exp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .round_keys  (round_keys)
    );

    saes_round_core u_round_core (
        .operation  (in_op_reg),
        .block_in   (in_block_reg),
        .round_keys (round_keys),
        .block_out  (core_block)
    );

    // Handshake: each stage advances when the stage after it is free.
    always_comb
    begin
        out_free       = !out_valid_reg || m_tready;
        stage_move     = in_valid_reg && out_free;
        s_tready       = !in_valid_reg || out_free;
        in_accept      = s_tvalid && s_tready;
        in_valid_next  = in_accept || (in_valid_reg && !stage_move);
        out_valid_next = stage_move || (out_valid_reg && !m_tready);
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg    <= s_tuser;
            in_block_reg <= s_tdata;
        end
        if (stage_move)
        begin
            out_block_reg <= core_block;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_block_reg;

endmodule

FILE: rtl/saes_checker.sv
// Port-level checker for the simplified AES cipher, bound to the top level.
`timescale 1ns / 1ps
`include "simplified_aes_cipher_defines.svh"

module saes_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled result keeps its valid and its data.
    `SAES_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // With the result register empty, the block always takes a request.
    `SAES_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "request refused with empty output")

    // A result rising on an empty output was accepted into the input register.
    `SAES_ASSERT_NOW(a_result_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without request")

endmodule

bind simplified_aes_cipher saes_checker u_saes_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/simplified_aes_cipher_tb.sv
// Self-checking testbench for the simplified AES cipher on 16-bit blocks.
`timescale 1ns / 1ps

module simplified_aes_cipher_tb;
    import saes_pkg::OP_ENCRYPT;
    import saes_pkg::OP_DECRYPT;

    // Watchdog limit in cycles without any request, result or key write.
    localparam int STALL_LIMIT = 2000;

    // Key schedule round constants and column mixing entries.
    localparam logic [7:0] KS_RC1    = 8'h80;
    localparam logic [7:0] KS_RC2    = 8'h30;
    localparam logic [3:0] FWD_DIAG  = 4'h1;
    localparam logic [3:0] FWD_OFF   = 4'h4;
    localparam logic [3:0] BACK_DIAG = 4'h9;
    localparam logic [3:0] BACK_OFF  = 4'h2;

    // Nibble substitution tables, forward and inverse.
    localparam logic [3:0] FWD_NIB [16] = '{
        4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
        4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
    };
    localparam logic [3:0] BACK_NIB [16] = '{
        4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
        4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] block_in
    logic        s_tuser;   // [0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] block_out

    // Key as the block holds it, and the results still owed by the block.
    logic [15:0] key_model;
    logic [15:0] pending_blocks[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_cycles;

    simplified_aes_cipher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Free-running 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Product of two field elements modulo x^4 + x + 1.
    function automatic logic [3:0] gf4_times(input logic [3:0] x, input logic [3:0] y);
        logic [3:0] acc;
        logic [3:0] shifted;
        acc     = '0;
        shifted = x;
        for (int i = 0; i < 4; i++)
        begin
            if (y[i])
            begin
                acc = acc ^ shifted;
            end
            // x^4 folds back to x + 1.
            shifted = {shifted[2:0], 1'b0} ^ (shifted[3] ? 4'h3 : 4'h0);
        end
        return acc;
    endfunction

    // Substitute every nibble of a word through the chosen table.
    function automatic logic [15:0] subst_nibbles(input logic [15:0] v, input bit inverse);
        logic [15:0] res;
        logic [3:0]  nib;
        res = '0;
        for (int i = 0; i < 4; i++)
        begin
            nib = v[4*i +: 4];
            res[4*i +: 4] = inverse ? BACK_NIB[nib] : FWD_NIB[nib];
        end
        return res;
    endfunction

    // Exchange the second and fourth nibbles of the state.
    function automatic logic [15:0] swap_row(input logic [15:0] v);
        return {v[15:12], v[3:0], v[7:4], v[11:8]};
    endfunction

    // Multiply both state columns by {d, o; o, d}.
    function automatic logic [15:0] mix_state(input logic [15:0] v, input logic [3:0] d,
                                              input logic [3:0] o);
        logic [15:0] res;
        logic [3:0]  top;
        logic [3:0]  bot;
        res = '0;
        for (int c = 0; c < 2; c++)
        begin
            top = v[15 - 8*c -: 4];
            bot = v[11 - 8*c -: 4];
            res[15 - 8*c -: 4] = gf4_times(d, top) ^ gf4_times(o, bot);
            res[11 - 8*c -: 4] = gf4_times(o, top) ^ gf4_times(d, bot);
        end
        return res;
    endfunction

    // Expected output block for one request under the current key.
    function automatic logic [15:0] cipher_block(input logic op, input logic [15:0] blk,
                                                 input logic [15:0] key);
        logic [7:0]  w2;
        logic [7:0]  w3;
        logic [7:0]  w4;
        logic [7:0]  w5;
        logic [7:0]  t;
        logic [15:0] k2;
        logic [15:0] k3;
        logic [15:0] st;
        t  = {key[3:0], key[7:4]};
        w2 = key[15:8] ^ KS_RC1 ^ {FWD_NIB[t[7:4]], FWD_NIB[t[3:0]]};
        w3 = w2 ^ key[7:0];
        t  = {w3[3:0], w3[7:4]};
        w4 = w2 ^ KS_RC2 ^ {FWD_NIB[t[7:4]], FWD_NIB[t[3:0]]};
        w5 = w4 ^ w3;
        k2 = {w2, w3};
        k3 = {w4, w5};
        if (op == OP_ENCRYPT)
        begin
            st = blk ^ key;
            st = swap_row(subst_nibbles(st, 1'b0));
            st = mix_state(st, FWD_DIAG, FWD_OFF) ^ k2;
            st = swap_row(subst_nibbles(st, 1'b0)) ^ k3;
        end
        else
        begin
            st = blk ^ k3;
            st = subst_nibbles(swap_row(st), 1'b1) ^ k2;
            st = mix_state(st, BACK_DIAG, BACK_OFF);
            st = subst_nibbles(swap_row(st), 1'b1) ^ key;
        end
        return st;
    endfunction

    // Offer one request, with random idle cycles ahead of it, and log its result.
    task automatic send_block(input logic op, input logic [15:0] blk);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pending_blocks.push_back(cipher_block(op, blk, key_model));
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic settle_pipeline();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_blocks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    // Write the key register while the block is idle.
    task automatic load_key(input logic [15:0] key);
        settle_pipeline();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= key;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        key_model = key;
    endtask

    // The key is still all zeros right after reset.
    task automatic test_power_on_key();
        send_block(OP_ENCRYPT, 16'h0000);
        send_block(OP_ENCRYPT, 16'hFFFF);
        send_block(OP_DECRYPT, 16'h0000);
        send_block(OP_DECRYPT, 16'hFFFF);
    endtask

    // The textbook key and block, both directions.
    task automatic test_textbook_vector();
        load_key(16'h4AF5);
        send_block(OP_ENCRYPT, 16'hD728);
        send_block(OP_DECRYPT, 16'h24EC);
    endtask

    // All-ones and all-zeros keys against extreme, single-bit and alternating blocks.
    task automatic test_key_extremes();
        load_key(16'hFFFF);
        send_block(OP_ENCRYPT, 16'h0000);
        send_block(OP_ENCRYPT, 16'hFFFF);
        send_block(OP_DECRYPT, 16'h0000);
        send_block(OP_DECRYPT, 16'hFFFF);
        send_block(OP_ENCRYPT, 16'h8000);
        send_block(OP_DECRYPT, 16'h0001);
        load_key(16'h0000);
        send_block(OP_ENCRYPT, 16'h0001);
        send_block(OP_DECRYPT, 16'h8000);
        send_block(OP_ENCRYPT, 16'h5A5A);
        send_block(OP_DECRYPT, 16'hA5A5);
    endtask

    // Random blocks in bursts, with a fresh key before each burst.
    task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
        int          sent;
        int          burst;
        logic [15:0] key;
        logic [15:0] plain;
        sent = 0;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        while (sent < n_items)
        begin
            case ($urandom_range(9))
                0: key = 16'h0000;
                1: key = 16'hFFFF;
                default: key = 16'($urandom);
            endcase
            load_key(key);
            burst = $urandom_range(40, 160);
            for (int i = 0; i < burst && sent < n_items; i++)
            begin
                plain = 16'($urandom);
                // Now and then send a ciphertext straight back for decryption.
                if ($urandom_range(3) == 0)
                begin
                    send_block(OP_ENCRYPT, plain);
                    send_block(OP_DECRYPT, cipher_block(OP_ENCRYPT, plain, key_model));
                    sent += 2;
                end
                else
                begin
                    send_block(logic'($urandom_range(1)), plain);
                    sent++;
                end
            end
        end
    endtask

    // Receiver side: random backpressure, changed at the falling edge.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each delivered block with the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_blocks.size() == 0)
            begin
                $display("%0t: unexpected block_out, expected none, got %h", $time, m_tdata);
                mismatches++;
            end
            else if (m_tdata !== pending_blocks[0])
            begin
                $display("%0t: block_out mismatch, expected %h, got %h",
                         $time, pending_blocks[0], m_tdata);
                mismatches++;
                void'(pending_blocks.pop_front());
            end
            else
            begin
                void'(pending_blocks.pop_front());
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simplified_aes_cipher_tb NOT OK");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Test sequence.
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_ENCRYPT;
        m_tready      = 1'b0;
        key_model     = '0;
        mismatches    = 0;
        stall_cycles  = 0;
        send_idle_pct = 0;
        recv_idle_pct = 40;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_on_key();
        test_textbook_vector();
        test_key_extremes();
        test_random_traffic(700, 30, 73);
        test_random_traffic(700, 73, 30);
        test_random_traffic(600, 0, 0);

        settle_pipeline();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("simplified_aes_cipher_tb OK");
        end
        else
        begin
            $display("simplified_aes_cipher_tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/saes_pkg.sv
rtl/saes_key_exp.sv
rtl/saes_round_core.sv
rtl/simplified_aes_cipher.sv
rtl/saes_checker.sv
sim/simplified_aes_cipher_tb.sv
